// File: src/time_weighted_window_average_defines.svh
// Assertion macros for the time-weighted window average block.
// Included by the top level; needs clk_i and rst_ni in scope.
`ifndef TIME_WEIGHTED_WINDOW_AVERAGE_DEFINES_SVH
`define TIME_WEIGHTED_WINDOW_AVERAGE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define TWA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication under reset.
`define TWA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TWA_ASSERT_IMP(label, ante, cons)
`define TWA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/twa_pkg.sv
// Shared widths and operation codes for the time-weighted window average.
// No dependencies.
package twa_pkg;
  localparam int unsigned LUX_W  = 24;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned WIN_W  = 32;
  localparam int unsigned ACC_W  = 56;

  typedef enum logic [1:0] {
    FUNC_OBSERVE = 2'd0,
    FUNC_RESET   = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_e;
endpackage

// File: src/twa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twa_ram #(
  parameter int unsigned Width = 72,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/twa_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on twa_pkg.
module twa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [twa_pkg::ACC_W-1:0] dividend_i,
  input  logic [twa_pkg::WIN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [twa_pkg::LUX_W-1:0] quotient_o
);
  import twa_pkg::*;

  localparam int unsigned CntW = $clog2(ACC_W);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [WIN_W-1:0] rem_q;
  logic [WIN_W-1:0] div_q;
  logic [ACC_W-1:0] quo_q;
  logic [WIN_W:0]   shifted;
  logic [WIN_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem_q, quo_q[ACC_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        done_o <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          done_o <= 1'b0;
        end
      end else begin
        done_o <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

  assign quotient_o = quo_q[LUX_W-1:0];
endmodule

// File: src/time_weighted_window_average.sv
// Time-weighted sliding window average of timestamped light samples.
// Depends on twa_pkg, twa_ram, twa_div and time_weighted_window_average_defines.svh.
//
// Channel  Dir  Handshake                    Contents
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: sample_lux, sample_time
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: average_lux
// cfg      in   cfg_we_i                     cfg_wdata_i: window_length
//
// Clear, reset, seed and stale-overwrite transactions go from ST_DEC straight
// to ST_OUT. An observe that integrates stored pairs and evicts old pairs
// walks the store one entry at a time through the single RAM read port, and
// the divider produces one quotient bit per cycle (56 bits).
// Input is taken only while the sequencer is idle; the output register lets
// one result wait while the next transaction is accepted.
// Reset is asynchronous, active low; the sample store needs no clearing.
module time_weighted_window_average #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,     // window_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,    // [1:0] func
  input  logic [71:0] s_axis_tdata,    // [23:0] sample_lux, [71:24] sample_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // [23:0] average_lux
);
  import twa_pkg::*;

  `include "time_weighted_window_average_defines.svh"

  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned RamW = TIME_W + LUX_W;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_DEC    = 13'b0000000000010,
    ST_EV_RD  = 13'b0000000000100,
    ST_EV_CK  = 13'b0000000001000,
    ST_SO_RD  = 13'b0000000010000,
    ST_SO_CK  = 13'b0000000100000,
    ST_IN_RD  = 13'b0000001000000,
    ST_IN_CK  = 13'b0000010000000,
    ST_IN_MUL = 13'b0000100000000,
    ST_IN_ACC = 13'b0001000000000,
    ST_DIV_GO = 13'b0010000000000,
    ST_DIV    = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_e;

  state_e            state_q;
  logic [WIN_W-1:0]  win_q;
  func_e             func_q;
  logic [LUX_W-1:0]  lux_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] newest_q;
  logic [TIME_W-1:0] cutoff_q;
  logic [AW-1:0]     head_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   k_q;
  logic [LUX_W-1:0]  last_q;
  logic [LUX_W-1:0]  res_q;
  logic [TIME_W-1:0] seg_start_q;
  logic [LUX_W-1:0]  prev_val_q;
  logic [LUX_W-1:0]  mval_q;
  logic [WIN_W-1:0]  seg_q;
  logic [WIN_W-1:0]  dur_q;
  logic [ACC_W-1:0]  prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic              m_valid_q;
  logic [LUX_W-1:0]  m_data_q;

  logic              in_acc;
  logic              can_load;
  logic [CntW-1:0]   off;
  logic [SumW-1:0]   idx_sum;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     head_inc;
  logic              ram_we;
  logic [RamW-1:0]   ram_wdata;
  logic [RamW-1:0]   ram_rdata;
  logic [TIME_W-1:0] rd_time;
  logic [LUX_W-1:0]  rd_lux;
  logic              empty;
  logic              stale;
  logic              full;
  logic [TIME_W-1:0] win_ext;
  logic [TIME_W-1:0] start_t;
  logic [TIME_W-1:0] dur_full;
  logic              div_start;
  logic              div_done;
  logic [LUX_W-1:0]  div_quo;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign can_load      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign rd_time  = ram_rdata[RamW-1:LUX_W];
  assign rd_lux   = ram_rdata[LUX_W-1:0];
  assign empty    = (cnt_q == '0);
  assign stale    = (now_q <= newest_q);
  assign full     = (cnt_q == CntW'(MAX_SAMPLES));
  assign win_ext  = {{(TIME_W-WIN_W){1'b0}}, win_q};
  assign start_t  = (rd_time > cutoff_q) ? rd_time : cutoff_q;
  assign dur_full = now_q - start_t;
  assign head_inc = (head_q == AW'(MAX_SAMPLES - 1)) ? '0 : head_q + 1'b1;
  assign div_start = (state_q == ST_DIV_GO);

  // Pick the store offset from the oldest entry for this step
  always_comb begin
    off = '0;
    case (state_q)
      ST_DEC: begin
        if (func_q == FUNC_OBSERVE && !empty) begin
          if (stale)     off = cnt_q - 1'b1;
          else if (full) off = '0;
          else           off = cnt_q;
        end
      end
      ST_EV_RD: off = CntW'(1);
      ST_IN_RD: off = k_q;
      default:  off = '0;
    endcase
  end

  // Wrap the circular index
  assign idx_sum = {{(SumW-AW){1'b0}}, head_q} + {1'b0, off};
  assign idx     = (idx_sum >= SumW'(MAX_SAMPLES)) ? AW'(idx_sum - SumW'(MAX_SAMPLES))
                                                  : idx_sum[AW-1:0];

  // Store write: seed, overwrite newest value, or append
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {now_q, lux_q};
    if (state_q == ST_DEC) begin
      case (func_q)
        FUNC_RESET: ram_we = 1'b1;
        FUNC_OBSERVE: begin
          ram_we = 1'b1;
          if (!empty && stale) ram_wdata = {newest_q, lux_q};
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  twa_ram #(
    .Width(RamW),
    .Depth(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx),
    .wdata_i(ram_wdata),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  twa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_q),
    .divisor_i (dur_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_q     <= WIN_W'(1000000);
      head_q    <= '0;
      cnt_q     <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) win_q <= cfg_wdata_i;
      // Load a result or drop the one just taken
      if (state_q == ST_OUT && can_load) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) state_q <= ST_DEC;
        end
        ST_DEC: begin
          case (func_q)
            FUNC_RESET: begin
              cnt_q   <= CntW'(1);
              last_q  <= lux_q;
              state_q <= ST_OUT;
            end
            FUNC_CLEAR: begin
              cnt_q   <= '0;
              last_q  <= '0;
              state_q <= ST_OUT;
            end
            FUNC_OBSERVE: begin
              if (empty) begin
                cnt_q   <= CntW'(1);
                last_q  <= lux_q;
                state_q <= ST_OUT;
              end else if (!stale) begin
                if (full) head_q <= head_inc;
                else      cnt_q  <= cnt_q + 1'b1;
                state_q <= ST_EV_RD;
              end else begin
                state_q <= ST_OUT;
              end
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_EV_RD: state_q <= (cnt_q > CntW'(1)) ? ST_EV_CK : ST_SO_RD;
        ST_EV_CK: begin
          // Drop the oldest pair while its successor is at or before the cutoff
          if (rd_time <= cutoff_q) begin
            head_q  <= head_inc;
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_EV_RD;
          end else begin
            state_q <= ST_SO_RD;
          end
        end
        ST_SO_RD: state_q <= ST_SO_CK;
        ST_SO_CK: state_q <= (dur_full == '0) ? ST_OUT : ST_IN_RD;
        ST_IN_RD: state_q <= ST_IN_CK;
        ST_IN_CK: state_q <= ST_IN_MUL;
        ST_IN_MUL: state_q <= ST_IN_ACC;
        ST_IN_ACC: state_q <= (k_q == cnt_q) ? ST_DIV_GO : ST_IN_RD;
        ST_DIV_GO: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            last_q  <= div_quo;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (can_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_q <= func_e'(s_axis_tuser);
          lux_q  <= s_axis_tdata[LUX_W-1:0];
          now_q  <= s_axis_tdata[RamW-1:LUX_W];
        end
      end
      ST_DEC: begin
        cutoff_q <= (now_q > win_ext) ? now_q - win_ext : '0;
        case (func_q)
          FUNC_RESET: begin
            newest_q <= now_q;
            res_q    <= lux_q;
          end
          FUNC_OBSERVE: begin
            if (empty) begin
              newest_q <= now_q;
              res_q    <= lux_q;
            end else if (stale) begin
              res_q <= last_q;
            end else begin
              newest_q <= now_q;
            end
          end
          default: res_q <= '0;
        endcase
      end
      ST_SO_CK: begin
        res_q       <= lux_q;
        dur_q       <= dur_full[WIN_W-1:0];
        seg_start_q <= start_t;
        prev_val_q  <= rd_lux;
        k_q         <= CntW'(1);
        acc_q       <= '0;
      end
      ST_IN_CK: begin
        // Segment of the previous value ends at this entry's time
        seg_q       <= WIN_W'(rd_time - seg_start_q);
        mval_q      <= prev_val_q;
        prev_val_q  <= rd_lux;
        seg_start_q <= rd_time;
        k_q         <= k_q + 1'b1;
      end
      ST_IN_MUL: prod_q <= ACC_W'(mval_q) * ACC_W'(seg_q);
      ST_IN_ACC: acc_q  <= acc_q + prod_q;
      ST_DIV: begin
        if (div_done) res_q <= div_quo;
      end
      ST_OUT: begin
        if (can_load) m_data_q <= res_q;
      end
      default: ;
    endcase
  end

  `TWA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(MAX_SAMPLES))
  `TWA_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `TWA_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)
endmodule

// File: test/time_weighted_window_average_tb.sv
// Testbench for the time-weighted sliding window average block.
// Depends on twa_pkg and the time_weighted_window_average top level.
module time_weighted_window_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twa_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned TIMEOUT_CYCLES = 900000;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  // Scoreboard: predicts the window average and checks each result
  class avg_scoreboard;
    logic [TIME_W-1:0] times[DEPTH];
    logic [LUX_W-1:0]  values[DEPTH];
    int unsigned       count;
    logic [LUX_W-1:0]  last_avg;
    logic [WIN_W-1:0]  win_len;
    logic [LUX_W-1:0]  pending_avg[$];
    int unsigned       mismatches;

    function void init();
      count = 0;
      last_avg = '0;
      win_len = 32'd1000000;
      pending_avg.delete();
      mismatches = 0;
    endfunction

    function void drop_oldest();
      if (count == 0) return;
      count--;
      for (int i = 0; i < count; i++) begin
        times[i] = times[i+1];
        values[i] = values[i+1];
      end
    endfunction

    function logic [LUX_W-1:0] observe(logic [LUX_W-1:0] lux, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] cutoff, start, seg_s, dur;
      logic [ACC_W+8-1:0] integ;
      if (count == 0) begin
        count = 1; times[0] = now; values[0] = lux; last_avg = lux;
        return lux;
      end
      if (now <= times[count-1]) begin
        values[count-1] = lux;
        return last_avg;
      end
      if (count >= DEPTH) drop_oldest();
      times[count] = now;
      values[count] = lux;
      count++;
      cutoff = (now > TIME_W'(win_len)) ? now - TIME_W'(win_len) : '0;
      while (count > 1 && times[1] <= cutoff) drop_oldest();
      start = (times[0] > cutoff) ? times[0] : cutoff;
      dur = now - start;
      if (dur == 0) return lux;
      integ = '0;
      for (int i = 0; i + 1 < count; i++) begin
        seg_s = (times[i] > start) ? times[i] : start;
        if (times[i+1] > seg_s) integ += values[i] * (times[i+1] - seg_s);
      end
      last_avg = LUX_W'(integ / dur);
      return last_avg;
    endfunction

    function void note_input(logic [1:0] fn, logic [LUX_W-1:0] lux, logic [TIME_W-1:0] t);
      logic [LUX_W-1:0] res;
      res = '0;
      case (fn)
        FUNC_OBSERVE: res = observe(lux, t);
        FUNC_RESET: begin
          count = 1; times[0] = t; values[0] = lux; last_avg = lux; res = lux;
        end
        FUNC_CLEAR: begin
          count = 0; last_avg = '0;
        end
        default: res = '0;
      endcase
      pending_avg.push_back(res);
    endfunction

    function void check_result(logic [LUX_W-1:0] got);
      logic [LUX_W-1:0] want;
      if (pending_avg.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", got);
        return;
      end
      want = pending_avg.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("average mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  avg_scoreboard sb;
  int unsigned   cycles = 0;
  bit            calm = 1'b0;      // no idling in the last part
  bit            hold_off = 1'b0;  // long receiver stall request
  logic [TIME_W-1:0] clock_us;

  time_weighted_window_average u_top (.*);

  // Clock and cycle limit
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Note accepted inputs and check accepted results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[71:24]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Receiver: random stall bursts, long hold-off on request
  initial begin
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < 3000; i++) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 18);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic [1:0] fn, logic [LUX_W-1:0] lux, logic [TIME_W-1:0] t);
    int unsigned gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {t, lux};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic write_window(logic [31:0] w);
    while (sb.pending_avg.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.win_len = w;
  endtask

  // Mostly advancing observes with some stale times, resets, clears and unused codes
  task automatic random_run(int unsigned n, int unsigned max_step);
    logic [1:0] fn;
    logic [TIME_W-1:0] t;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      fn = FUNC_OBSERVE;
      if (r < 3) fn = FUNC_CLEAR;
      else if (r < 6) fn = FUNC_RESET;
      else if (r < 8) fn = FUNC_UNUSED;
      if (r >= 8 && r < 16) t = clock_us - $urandom_range(0, 3);
      else begin
        clock_us += $urandom_range(1, max_step);
        t = clock_us;
      end
      if (r == 99) t = TIME_W'({$urandom, $urandom});
      send_item(fn, ($urandom_range(0, 3) == 0) ? 24'(-$urandom_range(0, 15)) : 24'($urandom),
                t);
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    clock_us = 48'd1000;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every operation and field extremes
    send_item(FUNC_OBSERVE, 24'd100, 48'd10);          // seed empty store
    send_item(FUNC_OBSERVE, 24'hFFFFFF, 48'd10);       // stale time overwrites
    send_item(FUNC_OBSERVE, 24'hFFFFFF, 48'd500010);
    send_item(FUNC_OBSERVE, 24'd0, 48'd2500000);       // evicts past window
    send_item(FUNC_UNUSED, 24'hFFFFFF, 48'hFFFFFFFFFFFF);  // unused code
    send_item(FUNC_RESET, 24'h123456, 48'd3000000);
    send_item(FUNC_OBSERVE, 24'h654321, 48'd2999999);  // older time
    send_item(FUNC_CLEAR, 24'hFFFFFF, 48'hFFFFFFFFFFFF);
    send_item(FUNC_OBSERVE, 24'd0, 48'd0);
    send_item(FUNC_OBSERVE, 24'hFFFFFF, 48'hFFFFFFFFFFFF);
    send_item(FUNC_CLEAR, 24'd0, 48'd0);
    for (int i = 0; i < 40; i++)                        // fills and wraps the store
      send_item(FUNC_OBSERVE, LUX_W'(24'hFFFFFF - i), 48'd100 + 48'(i));

    // Small window with full store churn
    write_window(32'd1);
    send_item(FUNC_OBSERVE, 24'd7, 48'd5000);
    send_item(FUNC_OBSERVE, 24'd9, 48'd5001);
    clock_us = 48'd6000;
    random_run(60, 3);

    write_window(32'd40);
    random_run(180, 3);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    random_run(40, 2);

    write_window(32'hFFFFFFFF);
    random_run(150, 50000);

    write_window(32'd0);
    random_run(40, 5);

    write_window(32'd2000);
    random_run(180, 200);

    write_window(32'd1000000);
    random_run(150, 40000);

    calm = 1'b1;
    random_run(120, 100);

    while (sb.pending_avg.size() != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_avg.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/twa_pkg.sv
src/twa_ram.sv
src/twa_div.sv
src/time_weighted_window_average.sv
test/time_weighted_window_average_tb.sv
